@@ hdl/flfsq_pkg.sv @@
// Shared types, constants and command encodings for the flicker lamp filter and squarer.
`timescale 1ns / 1ps

package flfsq_pkg;

    // Fixed field widths
    localparam int SAMPLE_W        = 16;
    localparam int COEF_W          = 32;
    localparam int RESP_W          = 32;
    localparam int SENS_W          = 48;
    localparam int STATE_WIDTH_DEF = 48;

    // Shared multiplier operand width (signed, holds a 32-bit unsigned chunk)
    localparam int MUL_W = 33;

    // Fixed-point alignment
    localparam int X_SHIFT = 60 - (SAMPLE_W - 1);
    localparam int W_SHIFT = 29;
    localparam int Y_SHIFT = 36;
    localparam int S_SHIFT = 15;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_A1 = 3'd0;
    localparam logic [2:0] REG_A2 = 3'd1;
    localparam logic [2:0] REG_B0 = 3'd2;
    localparam logic [2:0] REG_B1 = 3'd3;
    localparam logic [2:0] REG_B2 = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } in_item_t;

    typedef struct packed {
        logic signed [RESP_W-1:0] lamp_response;
        logic [SENS_W-1:0]        inst_sensation;
        logic                     saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
    } coef_t;

    // Operand pairs for the shared multiplier
    typedef enum logic [3:0] {
        MUL_A1_DN_LO,
        MUL_A1_DN_HI,
        MUL_A2_DO_LO,
        MUL_A2_DO_HI,
        MUL_B0_W_LO,
        MUL_B0_W_HI,
        MUL_B1_DN_LO,
        MUL_B1_DN_HI,
        MUL_B2_DO_LO,
        MUL_B2_DO_HI,
        MUL_Y_Y
    } mul_sel_t;

    typedef struct packed {
        logic     load;     // take a new transaction into the datapath
        logic     mul_en;   // capture the product of mul_sel
        mul_sel_t mul_sel;
        logic     acc_en;   // fold the held product into the accumulator
        logic     acc_sub;
        logic     acc_hi;   // held product came from an upper chunk
        logic     fin_w;    // round and clamp the new state word, restart accumulator
        logic     fin_y;    // round and clamp the response, restart accumulator
        logic     fin_s;    // finish sensation, load output, advance delay line
    } cmd_t;

endpackage

@@ hdl/flfsq_regs.sv @@
// APB coefficient register file.
`timescale 1ns / 1ps

module flfsq_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flfsq_pkg::ADDR_W-1:0]  paddr,
    input  logic [flfsq_pkg::DATA_W-1:0]  pwdata,
    output logic [flfsq_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output flfsq_pkg::coef_t              coef
);

    flfsq_pkg::coef_t coef_reg;
    flfsq_pkg::coef_t coef_next;
    logic             wr_en;
    logic [2:0]       idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];

    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            case (idx)
                flfsq_pkg::REG_A1: coef_next.a1 = pwdata;
                flfsq_pkg::REG_A2: coef_next.a2 = pwdata;
                flfsq_pkg::REG_B0: coef_next.b0 = pwdata;
                flfsq_pkg::REG_B1: coef_next.b1 = pwdata;
                flfsq_pkg::REG_B2: coef_next.b2 = pwdata;
                default:           coef_next    = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    always_comb
    begin
        case (idx)
            flfsq_pkg::REG_A1: prdata = coef_reg.a1;
            flfsq_pkg::REG_A2: prdata = coef_reg.a2;
            flfsq_pkg::REG_B0: prdata = coef_reg.b0;
            flfsq_pkg::REG_B1: prdata = coef_reg.b1;
            flfsq_pkg::REG_B2: prdata = coef_reg.b2;
            default:           prdata = '0;
        endcase
    end

    assign coef = coef_reg;

endmodule

@@ hdl/flfsq_ctrl.sv @@
// Sequencer for the shared multiplier and accumulator, plus the output handshake.
`timescale 1ns / 1ps

module flfsq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output flfsq_pkg::cmd_t   cmd
);

    // One-hot encoding, one state per step of the sequence
    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_A1_LO  = 15'h0002,
        S_A1_HI  = 15'h0004,
        S_A2_LO  = 15'h0008,
        S_A2_HI  = 15'h0010,
        S_B1_LO  = 15'h0020,
        S_W_FIN  = 15'h0040,
        S_B2_LO  = 15'h0080,
        S_B2_HI  = 15'h0100,
        S_B0_LO  = 15'h0200,
        S_B0_HI  = 15'h0400,
        S_B0_ACC = 15'h0800,
        S_Y_FIN  = 15'h1000,
        S_SQ     = 15'h2000,
        S_OUT    = 15'h4000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = flfsq_pkg::MUL_A1_DN_LO;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                begin
                    state_next = S_A1_LO;
                end
            end
            S_A1_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_A1_DN_LO;
                state_next  = S_A1_HI;
            end
            S_A1_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_A1_DN_HI;
                cmd.acc_en  = 1'b1;
                cmd.acc_sub = 1'b1;
                state_next  = S_A2_LO;
            end
            S_A2_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_A2_DO_LO;
                cmd.acc_en  = 1'b1;
                cmd.acc_sub = 1'b1;
                cmd.acc_hi  = 1'b1;
                state_next  = S_A2_HI;
            end
            S_A2_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_A2_DO_HI;
                cmd.acc_en  = 1'b1;
                cmd.acc_sub = 1'b1;
                state_next  = S_B1_LO;
            end
            S_B1_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_B1_DN_LO;
                cmd.acc_en  = 1'b1;
                cmd.acc_sub = 1'b1;
                cmd.acc_hi  = 1'b1;
                state_next  = S_W_FIN;
            end
            S_W_FIN:
            begin
                // accumulator holds the feedback sum; it restarts with b1 low
                cmd.fin_w   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_B1_DN_HI;
                cmd.acc_en  = 1'b1;
                state_next  = S_B2_LO;
            end
            S_B2_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_B2_DO_LO;
                cmd.acc_en  = 1'b1;
                cmd.acc_hi  = 1'b1;
                state_next  = S_B2_HI;
            end
            S_B2_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_B2_DO_HI;
                cmd.acc_en  = 1'b1;
                state_next  = S_B0_LO;
            end
            S_B0_LO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_B0_W_LO;
                cmd.acc_en  = 1'b1;
                cmd.acc_hi  = 1'b1;
                state_next  = S_B0_HI;
            end
            S_B0_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_B0_W_HI;
                cmd.acc_en  = 1'b1;
                state_next  = S_B0_ACC;
            end
            S_B0_ACC:
            begin
                cmd.acc_en = 1'b1;
                cmd.acc_hi = 1'b1;
                state_next = S_Y_FIN;
            end
            S_Y_FIN:
            begin
                cmd.fin_y  = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = flfsq_pkg::MUL_Y_Y;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                // hold here until the output register can take the result
                cmd.fin_s = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = cmd.fin_s || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_s |-> !(out_valid_reg && out_stall))
        else $error("output transaction overwritten while stalled");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_A1_LO))
        else $error("sequence did not start after accepted transaction");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.fin_s))
        else $error("output valid rose without a finished result");

endmodule

@@ hdl/flfsq_dp.sv @@
// Datapath: shared multiplier, accumulator, round and clamp, delay line, output register.
`timescale 1ns / 1ps

module flfsq_dp
#(
    parameter int STATE_WIDTH = flfsq_pkg::STATE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  flfsq_pkg::cmd_t       cmd,
    input  flfsq_pkg::in_item_t   in_data,
    input  flfsq_pkg::coef_t      coef,
    output flfsq_pkg::out_item_t  out_data
);

    localparam int SW    = STATE_WIDTH;
    localparam int LO_W  = SW / 2;
    localparam int ACC_W = SW + 40;
    localparam int MW    = flfsq_pkg::MUL_W;
    localparam int PW    = 2 * MW;
    localparam int RW    = flfsq_pkg::RESP_W;
    localparam int NW    = flfsq_pkg::SENS_W;
    localparam int WS    = flfsq_pkg::W_SHIFT;
    localparam int YS    = flfsq_pkg::Y_SHIFT;
    localparam int SS    = flfsq_pkg::S_SHIFT;

    logic signed [SW-1:0]    dn_reg, dn_next;
    logic signed [SW-1:0]    do_reg, do_next;
    logic signed [SW-1:0]    w_reg, w_next;
    logic signed [RW-1:0]    y_reg, y_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic                    sat_reg, sat_next;
    flfsq_pkg::out_item_t    out_reg, out_next;

    // Multiplier operands: low chunks are unsigned, high chunks carry the sign
    logic signed [MW-1:0]    dn_lo, dn_hi, do_lo, do_hi, w_lo, w_hi;
    logic signed [MW-1:0]    op_a, op_b;

    logic signed [ACC_W-1:0] prod_ext, term, acc_base, acc_sum;

    logic signed [ACC_W-1:0] w_rnd, y_rnd;
    logic [ACC_W-WS-SW:0]    w_top;
    logic [ACC_W-YS-RW:0]    y_top;
    logic                    w_fits, y_fits;
    logic signed [SW-1:0]    w_clip;
    logic signed [RW-1:0]    y_clip;

    logic [PW-1:0]           sq_rnd;
    logic [PW-SS-NW-1:0]     sens_top;
    logic                    sens_ovf;
    logic [NW-1:0]           sens;

    assign dn_lo = MW'(dn_reg[LO_W-1:0]);
    assign dn_hi = MW'($signed(dn_reg[SW-1:LO_W]));
    assign do_lo = MW'(do_reg[LO_W-1:0]);
    assign do_hi = MW'($signed(do_reg[SW-1:LO_W]));
    assign w_lo  = MW'(w_reg[LO_W-1:0]);
    assign w_hi  = MW'($signed(w_reg[SW-1:LO_W]));

    always_comb
    begin
        case (cmd.mul_sel)
            flfsq_pkg::MUL_A1_DN_LO: begin op_a = MW'(coef.a1); op_b = dn_lo; end
            flfsq_pkg::MUL_A1_DN_HI: begin op_a = MW'(coef.a1); op_b = dn_hi; end
            flfsq_pkg::MUL_A2_DO_LO: begin op_a = MW'(coef.a2); op_b = do_lo; end
            flfsq_pkg::MUL_A2_DO_HI: begin op_a = MW'(coef.a2); op_b = do_hi; end
            flfsq_pkg::MUL_B0_W_LO:  begin op_a = MW'(coef.b0); op_b = w_lo;  end
            flfsq_pkg::MUL_B0_W_HI:  begin op_a = MW'(coef.b0); op_b = w_hi;  end
            flfsq_pkg::MUL_B1_DN_LO: begin op_a = MW'(coef.b1); op_b = dn_lo; end
            flfsq_pkg::MUL_B1_DN_HI: begin op_a = MW'(coef.b1); op_b = dn_hi; end
            flfsq_pkg::MUL_B2_DO_LO: begin op_a = MW'(coef.b2); op_b = do_lo; end
            flfsq_pkg::MUL_B2_DO_HI: begin op_a = MW'(coef.b2); op_b = do_hi; end
            flfsq_pkg::MUL_Y_Y:      begin op_a = MW'(y_reg);   op_b = MW'(y_reg); end
            default:                 begin op_a = '0;           op_b = '0;    end
        endcase
    end

    assign prod_next = op_a * op_b;

    // Accumulate the product held from the previous cycle
    assign prod_ext = ACC_W'(prod_reg);
    assign term     = cmd.acc_hi ? (prod_ext <<< LO_W) : prod_ext;
    assign acc_base = (cmd.fin_w || cmd.fin_y) ? '0 : acc_reg;
    assign acc_sum  = cmd.acc_sub ? (acc_base - term) : (acc_base + term);

    // Round half up, then clamp
    assign w_rnd  = acc_reg + (ACC_W'(1) <<< (WS - 1));
    assign w_top  = w_rnd[ACC_W-1:WS+SW-1];
    assign w_fits = (&w_top) || !(|w_top);
    assign w_clip = w_fits ? w_rnd[WS+SW-1:WS]
                  : (w_rnd[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

    assign y_rnd  = acc_reg + (ACC_W'(1) <<< (YS - 1));
    assign y_top  = y_rnd[ACC_W-1:YS+RW-1];
    assign y_fits = (&y_top) || !(|y_top);
    assign y_clip = y_fits ? y_rnd[YS+RW-1:YS]
                  : (y_rnd[ACC_W-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}});

    // Square is never negative, so the sensation rounds as unsigned
    assign sq_rnd   = prod_reg + (PW'(1) << (SS - 1));
    assign sens_top = sq_rnd[PW-1:SS+NW];
    assign sens_ovf = |sens_top;
    assign sens     = sens_ovf ? {NW{1'b1}} : sq_rnd[SS+NW-1:SS];

    always_comb
    begin
        dn_next  = dn_reg;
        do_next  = do_reg;
        w_next   = w_reg;
        y_next   = y_reg;
        sat_next = sat_reg;
        out_next = out_reg;

        if (cmd.load)
        begin
            acc_next = ACC_W'(in_data.sample) <<< flfsq_pkg::X_SHIFT;
        end
        else if (cmd.acc_en)
        begin
            acc_next = acc_sum;
        end
        else
        begin
            acc_next = acc_base;
        end

        if (cmd.load)
        begin
            sat_next = 1'b0;
            if (in_data.restart)
            begin
                dn_next = '0;
                do_next = '0;
            end
        end

        if (cmd.fin_w)
        begin
            w_next   = w_clip;
            sat_next = sat_reg || !w_fits;
        end

        if (cmd.fin_y)
        begin
            y_next   = y_clip;
            sat_next = sat_reg || !y_fits;
        end

        if (cmd.fin_s)
        begin
            out_next.lamp_response  = y_reg;
            out_next.inst_sensation = sens;
            out_next.saturated      = sat_reg || sens_ovf;
            do_next                 = dn_reg;
            dn_next                 = w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dn_reg <= '0;
            do_reg <= '0;
        end
        else
        begin
            dn_reg <= dn_next;
            do_reg <= do_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        w_reg   <= w_next;
        y_reg   <= y_next;
        sat_reg <= sat_next;
        out_reg <= out_next;
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_data = out_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && in_data.restart) |=> (dn_reg == '0 && do_reg == '0))
        else $error("restart did not clear the delay line");

endmodule

@@ hdl/flicker_lamp_filter_squarer.sv @@
// Top level of the flicker lamp filter and squarer.
`timescale 1ns / 1ps

// Lamp filter and squaring stage of a flicker meter.
// Input channel (in_valid / in_stall / in_data): one signed sample per
// transaction plus a restart flag that zeroes the biquad state first.
// Output channel (out_valid / out_stall / out_data): one result per input
// transaction with the lamp response (Q8.24), the sensation 2*y^2 (Q16.32)
// and a saturation flag.
// Coefficients a1, a2, b0, b1, b2 (Q3.29) sit on the APB port at byte
// addresses 0, 4, 8, 12, 16; write them only while the block is idle.
// Samples are worked on one at a time by the one shared 33x33 multiplier,
// which issues eleven products per sample (five coefficient products split
// into two chunks each, then the square), with round and clamp steps for the
// state word and the response in between.
// in_stall is high while a sample is being worked on. A finished result sits
// in the output register; if that register is still stalled when the next
// result is ready, the sequencer holds until the receiver takes it.
// Reset clears the coefficients, the delay line and the output valid.

module flicker_lamp_filter_squarer
#(
    parameter int STATE_WIDTH = flfsq_pkg::STATE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  flfsq_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output flfsq_pkg::out_item_t          out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flfsq_pkg::ADDR_W-1:0]  paddr,
    input  logic [flfsq_pkg::DATA_W-1:0]  pwdata,
    output logic [flfsq_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    flfsq_pkg::coef_t coef;
    flfsq_pkg::cmd_t  cmd;

    flfsq_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    flfsq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    flfsq_dp
    #(
        .STATE_WIDTH (STATE_WIDTH)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .coef     (coef),
        .out_data (out_data)
    );

endmodule
